@@ sv/rmsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths, limits, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  // field and accumulator widths
  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 24;
  localparam int FRAC_BITS     = 8;
  localparam int MEAN_BITS     = 24;
  localparam int DEV_BITS      = 23;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int HALF_BITS     = SUM_BITS / 2;

  // shared multiplier and its products
  localparam int MUL_BITS      = 27;
  localparam int PROD_BITS     = 2 * MUL_BITS;
  localparam int NSS_BITS      = COUNT_BITS + SQ_BITS;
  localparam int S2_BITS       = 2 * SUM_BITS - 1;
  localparam int NSQ_BITS      = 2 * COUNT_BITS;

  // divider and root unit
  localparam int VAR_SHIFT     = NSS_BITS - NSQ_BITS;
  localparam int MEAN_SHIFT    = MEAN_BITS - FRAC_BITS;
  localparam int QUO_BITS      = 2 * DEV_BITS;
  localparam int DIV_BITS      = NSQ_BITS;
  localparam int ITER_BITS     = $clog2(QUO_BITS + 1);
  localparam int SQRT_REM_BITS = DEV_BITS + 2;
  localparam int SQRT_CNT_BITS = $clog2(DEV_BITS + 1);

  // stream words
  localparam int IN_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = COUNT_BITS + MEAN_BITS + DEV_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [MEAN_BITS-1:0]  MEAN_POS_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};
  localparam logic [MEAN_BITS-1:0]  MEAN_NEG_MAX = {1'b1, {(MEAN_BITS-1){1'b0}}};
  localparam logic [DEV_BITS-1:0]   DEV_MAX      = '1;

  // mode codes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // multiplier operations; the first six run in sequence from a step count
  typedef enum logic [2:0] {
    OP_NSS_LO,
    OP_NSS_HI,
    OP_MAG_LL,
    OP_MAG_LH,
    OP_MAG_HH,
    OP_N_SQ,
    OP_SAMPLE
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MAG,
    ST_START,
    ST_MEAN,
    ST_VAR_PREP,
    ST_VAR_LOAD,
    ST_VAR_DIV,
    ST_SQRT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    take_in;
    logic    mul_en;
    mul_op_t mul_op;
    logic    accum;
    logic    load_mag;
    logic    div_mean;
    logic    div_var;
    logic    sqrt_start;
    logic    take_mean;
    logic    load_diff;
    logic    load_out;
  } rmsd_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } rmsd_status_t;

endpackage
`default_nettype wire

@@ sv/running_mean_std_dev.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_std_dev
// Running count, mean and population standard deviation of a sample stream.
// ----------------------------------------------------------------------------
// A word is accepted only after the result of the one before it has gone to
//   the output register. The divisions and root are skipped when the set is
//   empty after the word (clear, or no samples yet); else the shared restoring
//   divider (24 mean bits, then 46 variance bits) and 23-step root set the pace.
// The result sits in an output register, so the next word is taken while it
//   waits for the sink.
// Reset (rst, synchronous, active high) empties the statistics, idles the
//   sequencer and drops any result word not yet taken.
// ----------------------------------------------------------------------------
//
// Each word either clears the statistics (s_tuser = 1) or adds one signed
// sample. After every word the block reports
//   point_total : samples held, stops counting when full (a sample arriving
//                 at a full count is dropped and the result is recomputed)
//   mean_value  : sum / n, signed, 8 fraction bits, toward zero, saturating
//   deviation   : floor(sqrt((n*sumsq - sum^2) * 2^16 / n^2)), saturating
// Both are zero for an empty set.
//
// Flow per word:
//   square sample -> update count/sum/sumsq -> take |sum|
//   -> mean division, meanwhile n*sumsq, sum^2 and n^2 on the multiplier
//   -> variance numerator -> variance division -> square root -> output
module running_mean_std_dev (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rmsd_pkg::IN_DATA_BITS-1:0]  s_tdata,   // [15:0] sample (signed)
  input  logic                               s_tuser,   // [0] mode: 0 add, 1 clear
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rmsd_pkg::OUT_DATA_BITS-1:0] m_tdata    // [23:0] point_total,
                                                        // [47:24] mean_value,
                                                        // [70:48] deviation,
                                                        // [71] zero
);
  import rmsd_pkg::*;

  rmsd_cmd_t    cmd;
  rmsd_status_t status;

  // sequencer
  rmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic and result register
  rmsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

@@ sv/rmsd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsd_div
// Restoring divider, one quotient bit per cycle, shared by mean and variance.
// ----------------------------------------------------------------------------
module rmsd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rmsd_pkg::DIV_BITS-1:0]  rem_init,   // dividend bits above the quotient
  input  logic [rmsd_pkg::QUO_BITS-1:0]  bits_init,  // remaining dividend bits, MSB first
  input  logic [rmsd_pkg::DIV_BITS-1:0]  divisor_in,
  input  logic [rmsd_pkg::ITER_BITS-1:0] iters,
  output logic                           busy,
  output logic [rmsd_pkg::QUO_BITS-1:0]  quotient
);
  import rmsd_pkg::*;

  logic [DIV_BITS-1:0]  rem;
  logic [QUO_BITS-1:0]  bits;
  logic [DIV_BITS-1:0]  divisor;
  logic [QUO_BITS-1:0]  quo;
  logic [ITER_BITS-1:0] cnt;
  logic [DIV_BITS:0]    rem_sh;
  logic [DIV_BITS:0]    rem_diff;
  logic                 ge;

  assign rem_sh   = {rem, bits[QUO_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - ITER_BITS'(1);
      if (cnt == ITER_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= rem_init;
      bits    <= bits_init;
      divisor <= divisor_in;
      quo     <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
      bits <= {bits[QUO_BITS-2:0], 1'b0};
      quo  <= {quo[QUO_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/rmsd_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsd_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rmsd_pkg::QUO_BITS-1:0] radicand,
  output logic                          busy,
  output logic [rmsd_pkg::DEV_BITS-1:0] root
);
  import rmsd_pkg::*;

  logic [QUO_BITS-1:0]      rad;
  logic [SQRT_REM_BITS-1:0] rem;
  logic [SQRT_CNT_BITS-1:0] cnt;
  logic [SQRT_REM_BITS+1:0] rem_sh;
  logic [SQRT_REM_BITS+1:0] trial;
  logic [SQRT_REM_BITS+1:0] rem_diff;
  logic                     ge;

  assign rem_sh   = {rem, rad[QUO_BITS-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign ge       = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SQRT_CNT_BITS'(DEV_BITS);
    end else if (busy) begin
      cnt <= cnt - SQRT_CNT_BITS'(1);
      if (cnt == SQRT_CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[QUO_BITS-3:0], 2'b00};
      rem  <= ge ? rem_diff[SQRT_REM_BITS-1:0] : rem_sh[SQRT_REM_BITS-1:0];
      root <= {root[DEV_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/rmsd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsd_ctrl
// Sequencer: accumulate, mean divide with products, variance divide, root.
// ----------------------------------------------------------------------------
module rmsd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output rmsd_pkg::rmsd_cmd_t    cmd,
  input  rmsd_pkg::rmsd_status_t status
);
  import rmsd_pkg::*;

  localparam logic [2:0] MUL_STEPS = 3'd6;
  localparam logic [2:0] MUL_DONE  = 3'd7;

  state_t     state;
  state_t     state_next;
  logic [2:0] mstep;
  logic       mul_done;

  assign mul_done = (mstep == MUL_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mstep <= '0;
    end else begin
      state <= state_next;
      if (state == ST_START) begin
        mstep <= '0;
      end else if (state == ST_MEAN && !mul_done) begin
        mstep <= mstep + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SQUARE;
      ST_SQUARE:   state_next = ST_ACCUM;
      ST_ACCUM:    state_next = ST_MAG;
      ST_MAG:      state_next = ST_START;
      ST_START:    state_next = status.empty ? ST_FINISH : ST_MEAN;
      ST_MEAN:     if (!status.div_busy && mul_done) state_next = ST_VAR_PREP;
      ST_VAR_PREP: state_next = ST_VAR_LOAD;
      ST_VAR_LOAD: state_next = ST_VAR_DIV;
      ST_VAR_DIV:  if (!status.div_busy) state_next = ST_SQRT;
      ST_SQRT:     if (!status.sqrt_busy) state_next = ST_FINISH;
      ST_FINISH:   if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_op = OP_SAMPLE;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_SQUARE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_SAMPLE;
      end
      ST_ACCUM:    cmd.accum = 1'b1;
      ST_MAG:      cmd.load_mag = 1'b1;
      ST_START:    cmd.div_mean = !status.empty;
      ST_MEAN: begin
        cmd.mul_en = (mstep < MUL_STEPS);
        cmd.mul_op = mul_op_t'(mstep);
      end
      ST_VAR_PREP: begin
        cmd.take_mean = 1'b1;
        cmd.load_diff = 1'b1;
      end
      ST_VAR_LOAD: cmd.div_var = 1'b1;
      ST_VAR_DIV:  cmd.sqrt_start = !status.div_busy;
      ST_SQRT:     ;
      ST_FINISH:   cmd.load_out = status.out_free;
      default:     ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/rmsd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmsd_dp
// Statistics registers, shared multiplier, divider, root unit, output word.
// ----------------------------------------------------------------------------
module rmsd_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  rmsd_pkg::rmsd_cmd_t                cmd,
  output rmsd_pkg::rmsd_status_t             status,
  input  logic [rmsd_pkg::IN_DATA_BITS-1:0]  in_data,
  input  logic                               in_user,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rmsd_pkg::OUT_DATA_BITS-1:0] out_data
);
  import rmsd_pkg::*;

  logic                   in_mode;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [SAMPLE_BITS-1:0] smag;

  logic [COUNT_BITS-1:0]  point_count;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SQ_BITS-1:0]     square_sum;

  logic [SUM_BITS-1:0]    mag;
  logic                   mag_neg;
  logic                   empty;

  logic [MUL_BITS-1:0]    mul_a;
  logic [MUL_BITS-1:0]    mul_b;
  logic [PROD_BITS-1:0]   prod;
  logic                   prod_valid;
  mul_op_t                prod_op;

  logic [NSS_BITS-1:0]    nss;
  logic [S2_BITS-1:0]     s2;
  logic [NSQ_BITS-1:0]    nsq;
  logic [NSS_BITS+1:0]    diff;
  logic [NSS_BITS-1:0]    var_num;

  logic                   mean_sat;
  logic                   var_sat;
  logic [MEAN_BITS-1:0]   mean_q;
  logic [MEAN_BITS-1:0]   mean_clamp;
  logic [MEAN_BITS-1:0]   mean_res;

  logic                   div_start;
  logic [DIV_BITS-1:0]    div_rem_init;
  logic [QUO_BITS-1:0]    div_bits_init;
  logic [DIV_BITS-1:0]    div_divisor;
  logic [ITER_BITS-1:0]   div_iters;
  logic                   div_busy;
  logic [QUO_BITS-1:0]    div_quo;

  logic                   sqrt_busy;
  logic [DEV_BITS-1:0]    sqrt_root;
  logic [DEV_BITS-1:0]    dev_res;

  // ---- input word ----
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_mode   <= in_user;
      in_sample <= in_data[SAMPLE_BITS-1:0];
    end
  end

  assign smag = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;

  // ---- shared multiplier ----
  always_comb begin
    case (cmd.mul_op)
      OP_NSS_LO: begin
        mul_a = {{(MUL_BITS-COUNT_BITS){1'b0}}, point_count};
        mul_b = square_sum[MUL_BITS-1:0];
      end
      OP_NSS_HI: begin
        mul_a = {{(MUL_BITS-COUNT_BITS){1'b0}}, point_count};
        mul_b = square_sum[SQ_BITS-1:MUL_BITS];
      end
      OP_MAG_LL: begin
        mul_a = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[HALF_BITS-1:0]};
        mul_b = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[HALF_BITS-1:0]};
      end
      OP_MAG_LH: begin
        mul_a = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[HALF_BITS-1:0]};
        mul_b = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[SUM_BITS-1:HALF_BITS]};
      end
      OP_MAG_HH: begin
        mul_a = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[SUM_BITS-1:HALF_BITS]};
        mul_b = {{(MUL_BITS-HALF_BITS){1'b0}}, mag[SUM_BITS-1:HALF_BITS]};
      end
      OP_N_SQ: begin
        mul_a = {{(MUL_BITS-COUNT_BITS){1'b0}}, point_count};
        mul_b = {{(MUL_BITS-COUNT_BITS){1'b0}}, point_count};
      end
      default: begin
        mul_a = {{(MUL_BITS-SAMPLE_BITS){1'b0}}, smag};
        mul_b = {{(MUL_BITS-SAMPLE_BITS){1'b0}}, smag};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod    <= mul_a * mul_b;
      prod_op <= cmd.mul_op;
    end
  end

  // partial products gather in the cycle after their multiplier step
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      case (prod_op)
        OP_NSS_LO: nss <= {{(NSS_BITS-PROD_BITS){1'b0}}, prod};
        OP_NSS_HI: nss <= nss + ({{(NSS_BITS-PROD_BITS){1'b0}}, prod} << MUL_BITS);
        OP_MAG_LL: s2  <= {{(S2_BITS-PROD_BITS){1'b0}}, prod};
        OP_MAG_LH: s2  <= s2 + ({{(S2_BITS-PROD_BITS){1'b0}}, prod} << (HALF_BITS + 1));
        OP_MAG_HH: s2  <= s2 + ({{(S2_BITS-PROD_BITS){1'b0}}, prod} << SUM_BITS);
        OP_N_SQ:   nsq <= prod[NSQ_BITS-1:0];
        default:   ;
      endcase
    end
  end

  // ---- statistics ----
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      running_sum <= '0;
      square_sum  <= '0;
    end else if (cmd.accum) begin
      if (in_mode == MODE_CLEAR) begin
        point_count <= '0;
        running_sum <= '0;
        square_sum  <= '0;
      end else if (point_count != COUNT_MAX) begin
        // a full count ignores the sample
        point_count <= point_count + COUNT_BITS'(1);
        running_sum <= running_sum
                     + {{(SUM_BITS-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
        square_sum  <= square_sum + prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mag) begin
      mag_neg <= running_sum[SUM_BITS-1];
      mag     <= running_sum[SUM_BITS-1] ? (~running_sum + SUM_BITS'(1)) : running_sum;
      empty   <= (point_count == '0);
    end
  end

  // ---- variance numerator n*sumsq - sum^2 ----
  assign diff = {2'b00, nss} - {1'b0, s2};

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      var_num <= diff[NSS_BITS+1] ? '0 : diff[NSS_BITS-1:0];
    end
  end

  // ---- divider ----
  assign div_start = cmd.div_mean | cmd.div_var;

  always_comb begin
    if (cmd.div_var) begin
      div_rem_init  = var_num[NSS_BITS-1:VAR_SHIFT];
      div_bits_init = {var_num[VAR_SHIFT-1:0], {(QUO_BITS-VAR_SHIFT){1'b0}}};
      div_divisor   = nsq;
      div_iters     = ITER_BITS'(QUO_BITS);
    end else begin
      div_rem_init  = {{(DIV_BITS-SUM_BITS+MEAN_SHIFT){1'b0}}, mag[SUM_BITS-1:MEAN_SHIFT]};
      div_bits_init = {mag[MEAN_SHIFT-1:0], {(QUO_BITS-MEAN_SHIFT){1'b0}}};
      div_divisor   = {{(DIV_BITS-COUNT_BITS){1'b0}}, point_count};
      div_iters     = ITER_BITS'(MEAN_BITS);
    end
  end

  // a quotient that would not fit is caught as the division starts
  always_ff @(posedge clk) begin
    if (cmd.div_mean) begin
      mean_sat <= (mag >= {point_count, {MEAN_SHIFT{1'b0}}});
    end
    if (cmd.div_var) begin
      var_sat <= (var_num >= {nsq, {VAR_SHIFT{1'b0}}});
    end
  end

  rmsd_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .rem_init   (div_rem_init),
    .bits_init  (div_bits_init),
    .divisor_in (div_divisor),
    .iters      (div_iters),
    .busy       (div_busy),
    .quotient   (div_quo)
  );

  // ---- mean ----
  assign mean_q = div_quo[MEAN_BITS-1:0];

  always_comb begin
    if (mag_neg) begin
      mean_clamp = (mean_sat || mean_q > MEAN_NEG_MAX) ? MEAN_NEG_MAX : mean_q;
      mean_res   = ~mean_clamp + MEAN_BITS'(1);
    end else begin
      mean_clamp = (mean_sat || mean_q > MEAN_POS_MAX) ? MEAN_POS_MAX : mean_q;
      mean_res   = mean_clamp;
    end
  end

  logic [MEAN_BITS-1:0] mean_hold;

  always_ff @(posedge clk) begin
    if (cmd.take_mean) begin
      mean_hold <= mean_res;
    end
  end

  // ---- deviation ----
  rmsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (div_quo),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  assign dev_res = var_sat ? DEV_MAX : sqrt_root;

  // ---- output word ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (empty) begin
        out_data <= {{(OUT_DATA_BITS-COUNT_BITS){1'b0}}, point_count};
      end else begin
        out_data <= {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, dev_res, mean_hold, point_count};
      end
    end
  end

  assign status.empty     = empty;
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

@@ tb/sv/running_mean_std_dev_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_std_dev_tb
// Self-checking bench for the running count, mean and deviation block.
// A short table of hand-picked words runs first. Its easy rows carry typed
// results and the rest go through the bench's own statistics model. About
// 1500 random words follow, grouped into runs between clears. Both stream
// sides idle at random, and now and then neither side idles for a stretch.
// ----------------------------------------------------------------------------
module running_mean_std_dev_tb;
  import rmsd_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SETTLE_TIME  = 150;     // cycles past the last result
  localparam int ROWS         = 21;

  typedef struct packed {
    logic [COUNT_BITS-1:0] total;
    logic [MEAN_BITS-1:0]  mean;
    logic [DEV_BITS-1:0]   dev;
  } stats_t;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   typed;   // row carries its own result
    stats_t                 result;
  } warmup_row_t;

  logic                     clk;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata  = '0;   // [15:0] sample
  logic                     s_tuser  = 1'b0; // [0] mode
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;         // [23:0] total, [47:24] mean, [70:48] dev

  // bench copy of the statistics
  logic [COUNT_BITS-1:0]        stats_count;
  logic signed [SUM_BITS-1:0]   stats_sum;
  logic [SQ_BITS-1:0]           stats_sqsum;

  stats_t stats_due[$];   // results still owed by the block, oldest first
  int     mismatches  = 0;
  int     cycle_count = 0;
  int     sink_wait   = 0;
  bit     calm        = 1'b0;  // no new idle gap on either side while set

  running_mean_std_dev u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    if (pick < 97) return $urandom_range(5, 30);
    return $urandom_range(31, 250);
  endfunction

  function automatic logic [DEV_BITS:0] floor_root(logic [47:0] v);
    logic [23:0] root;
    logic [23:0] trial;
    root = '0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (24'd1 << b);
      if ({24'd0, trial} * {24'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  // Applies one word to the bench statistics and returns the result word.
  function automatic stats_t update_stats(logic mode, logic [SAMPLE_BITS-1:0] sample);
    stats_t                 res;
    logic                   neg;
    logic [SUM_BITS-1:0]    mag40;
    logic [127:0]           mag, n, mean_mag, nss, s2, diff, var_q;
    logic [DEV_BITS:0]      root;
    longint                 sq;
    if (mode == MODE_CLEAR) begin
      stats_count = '0;
      stats_sum   = '0;
      stats_sqsum = '0;
    end else if (stats_count != COUNT_MAX) begin
      // a full count drops the sample; the sums are left alone
      sq          = longint'($signed(sample)) * longint'($signed(sample));
      stats_sum   = stats_sum + SUM_BITS'($signed(sample));
      stats_sqsum = stats_sqsum + SQ_BITS'(sq);
      stats_count = stats_count + COUNT_BITS'(1);
    end

    res.total = stats_count;
    if (stats_count == '0) begin
      res.mean = '0;
      res.dev  = '0;
      return res;
    end

    neg   = stats_sum[SUM_BITS-1];
    mag40 = neg ? SUM_BITS'(-stats_sum) : SUM_BITS'(stats_sum);
    mag   = 128'(mag40);
    n     = 128'(stats_count);

    // mean toward zero, saturating at either end
    mean_mag = (mag << FRAC_BITS) / n;
    if (neg) begin
      if (mean_mag > 128'(MEAN_NEG_MAX)) mean_mag = 128'(MEAN_NEG_MAX);
      res.mean = -mean_mag[MEAN_BITS-1:0];
    end else begin
      if (mean_mag > 128'(MEAN_POS_MAX)) mean_mag = 128'(MEAN_POS_MAX);
      res.mean = mean_mag[MEAN_BITS-1:0];
    end

    // variance kept exact as (n*sumsq - sum^2) * 2^16 / n^2, negative clamps to zero
    nss  = n * 128'(stats_sqsum);
    s2   = mag * mag;
    diff = (nss >= s2) ? nss - s2 : '0;
    var_q = (diff << (2 * FRAC_BITS)) / (n * n);
    if (var_q > (128'd1 << 47)) var_q = 128'd1 << 47;
    root = floor_root(var_q[47:0]);
    res.dev = (root > {1'b0, DEV_MAX}) ? DEV_MAX : root[DEV_BITS-1:0];
    return res;
  endfunction

  // One word through the input handshake; returns at the accepting edge.
  task automatic send_word(input logic mode, input logic [SAMPLE_BITS-1:0] sample);
    int gap;
    gap = calm ? 0 : idle_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_DATA_BITS'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sender holds off until the block has handed back every result.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  // Sample shapes for the random runs; base is the centre of the current run.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(logic [SAMPLE_BITS-1:0] base);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return SAMPLE_BITS'($urandom);
    if (pick < 55) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if (pick < 75) return SAMPLE_BITS'($urandom_range(0, 30) - 15);
    if (pick < 90) return base + SAMPLE_BITS'($urandom_range(0, 6) - 3);
    if (pick < 95) return 16'h1 << $urandom_range(0, SAMPLE_BITS - 1);
    return ~(16'h1 << $urandom_range(0, SAMPLE_BITS - 1));
  endfunction

  // Sink side: ready drops for random spells; no new spell starts while the bench is calm.
  always @(posedge clk) begin
    if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) sink_wait <= idle_gap() + 1;
    end
  end

  // Result checker: every accepted word against the oldest expectation.
  stats_t seen, due;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.total = m_tdata[23:0];
      seen.mean  = m_tdata[47:24];
      seen.dev   = m_tdata[70:48];
      if (stats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, total %0d mean %0d dev %0d",
                 $realtime, seen.total, $signed(seen.mean), seen.dev);
      end else begin
        due = stats_due.pop_front();
        if (seen.total !== due.total) begin
          mismatches++;
          $display("%0t: point_total expected %0d actual %0d",
                   $realtime, due.total, seen.total);
        end
        if (seen.mean !== due.mean) begin
          mismatches++;
          $display("%0t: mean_value expected %0d actual %0d",
                   $realtime, $signed(due.mean), $signed(seen.mean));
        end
        if (seen.dev !== due.dev) begin
          mismatches++;
          $display("%0t: deviation expected %0d actual %0d",
                   $realtime, due.dev, seen.dev);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hand-picked opening words. A full count needs 2^24-1 samples and is out
  // of reach in a run of this length, so it is not visited.
  warmup_row_t warmup_rows [ROWS];

  initial begin
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] base;
    stats_t                 res;

    warmup_rows = '{
      // clear on an empty set
      '{MODE_CLEAR, 16'h0000, 1'b1, '{24'd0, 24'h000000, 23'd0}},
      // most negative sample: mean sits exactly on the negative limit
      '{MODE_ADD,   16'h8000, 1'b1, '{24'd1, 24'h800000, 23'd0}},
      '{MODE_ADD,   16'h8000, 1'b1, '{24'd2, 24'h800000, 23'd0}},
      // clear ignores the sample, twice in a row
      '{MODE_CLEAR, 16'hFFFF, 1'b1, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_CLEAR, 16'h1234, 1'b1, '{24'd0, 24'h000000, 23'd0}},
      // most positive sample alone
      '{MODE_ADD,   16'h7FFF, 1'b1, '{24'd1, 24'h7FFF00, 23'd0}},
      // full swing: widest spread the fields allow
      '{MODE_ADD,   16'h8000, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h0000, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_CLEAR, 16'h8000, 1'b1, '{24'd0, 24'h000000, 23'd0}},
      // zeros, then 1, -1 and alternating bit patterns
      '{MODE_ADD,   16'h0000, 1'b1, '{24'd1, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h0000, 1'b1, '{24'd2, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h0001, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'hFFFF, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h5555, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'hAAAA, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_CLEAR, 16'h0000, 1'b1, '{24'd0, 24'h000000, 23'd0}},
      // -1 then +1: mean zero, deviation exactly one
      '{MODE_ADD,   16'hFFFF, 1'b1, '{24'd1, 24'hFFFF00, 23'd0}},
      '{MODE_ADD,   16'h0001, 1'b1, '{24'd2, 24'h000000, 23'd256}},
      '{MODE_ADD,   16'h7FFF, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h7FFF, 1'b0, '{24'd0, 24'h000000, 23'd0}},
      '{MODE_ADD,   16'h8000, 1'b0, '{24'd0, 24'h000000, 23'd0}}
    };

    stats_count = '0;
    stats_sum   = '0;
    stats_sqsum = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (warmup_rows[r]) begin
      send_word(warmup_rows[r].mode, warmup_rows[r].sample);
      res = update_stats(warmup_rows[r].mode, warmup_rows[r].sample);
      stats_due.push_back(warmup_rows[r].typed ? warmup_rows[r].result : res);
    end
    drain();

    base = SAMPLE_BITS'($urandom);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 4) == 0);
      if (i == RANDOM_WORDS / 2) drain();
      if ($urandom_range(0, 49) == 0) begin
        mode   = MODE_CLEAR;
        sample = SAMPLE_BITS'($urandom);
        base   = SAMPLE_BITS'($urandom);
      end else begin
        mode   = MODE_ADD;
        sample = draw_sample(base);
      end
      send_word(mode, sample);
      stats_due.push_back(update_stats(mode, sample));
    end
    calm = 1'b0;
    drain();

    repeat (SETTLE_TIME) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rmsd_pkg.sv
sv/rmsd_div.sv
sv/rmsd_sqrt.sv
sv/rmsd_ctrl.sv
sv/rmsd_dp.sv
sv/running_mean_std_dev.sv
tb/sv/running_mean_std_dev_tb.sv
